>>> rtl/lrs_pkg.sv
// Shared constants for the Life row stepper: field widths, register indexes,
// rule counts and result queue sizing. No dependencies.
package lrs_pkg;

	localparam int MAX_WIDTH_DEF = 64;
	localparam int MAX_HEIGHT    = 4096;

	localparam int INDEX_W    = 12;
	localparam int GWIDTH_W   = 7;
	localparam int HEIGHT_W   = 13;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT = 2'd1;

	localparam logic [GWIDTH_W-1:0] GRID_WIDTH_RST  = 7'd64;
	localparam logic [HEIGHT_W-1:0] GRID_HEIGHT_RST = 13'd1;

	localparam int NBR_CNT_W = 4;
	localparam logic [NBR_CNT_W-1:0] BIRTH_COUNT   = 4'd3;
	localparam logic [NBR_CNT_W-1:0] SURVIVE_COUNT = 4'd2;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QLVL_W = $clog2(QDEPTH + 1);

endpackage

>>> rtl/lrs_lane.sv
// One cell lane: counts the eight neighbors and applies the B3/S23 rule.
// Depends on lrs_pkg.
module lrs_lane (
	input  logic [2:0] above,
	input  logic [2:0] here,
	input  logic [2:0] below,
	output logic       next
);
	import lrs_pkg::*;

	logic [NBR_CNT_W-1:0] count;

	always_comb begin
		count = NBR_CNT_W'(above[0]) + NBR_CNT_W'(above[1]) + NBR_CNT_W'(above[2])
		      + NBR_CNT_W'(here[0])  + NBR_CNT_W'(here[2])
		      + NBR_CNT_W'(below[0]) + NBR_CNT_W'(below[1]) + NBR_CNT_W'(below[2]);
		next  = (count == BIRTH_COUNT) || (here[1] && (count == SURVIVE_COUNT));
	end

endmodule

>>> rtl/lrs_row_eval.sv
// Row evaluator: one lrs_lane per cell, then a merge that gathers the lane
// outputs into a row and clears cells beyond the used width. Depends on lrs_lane.
module lrs_row_eval #(
	parameter int MW = lrs_pkg::MAX_WIDTH_DEF
) (
	input  logic [MW-1:0] above,
	input  logic [MW-1:0] here,
	input  logic [MW-1:0] below,
	input  logic [MW-1:0] mask,
	output logic [MW-1:0] next
);
	// Dead cells are padded on both sides so edge lanes see no neighbors.
	logic [MW+1:0] above_pad;
	logic [MW+1:0] here_pad;
	logic [MW+1:0] below_pad;
	logic [MW-1:0] lane_out;

	assign above_pad = {1'b0, above, 1'b0};
	assign here_pad  = {1'b0, here, 1'b0};
	assign below_pad = {1'b0, below, 1'b0};

	for (genvar i = 0; i < MW; i++) begin : g_lane
		lrs_lane u_lane (
			.above (above_pad[i+2:i]),
			.here  (here_pad[i+2:i]),
			.below (below_pad[i+2:i]),
			.next  (lane_out[i])
		);
	end

	assign next = lane_out & mask;

endmodule

>>> rtl/lrs_result_queue.sv
// Small result queue taking up to two results per cycle and giving one.
// Entries are flops; the head entry drives the output directly. Depends on lrs_pkg.
module lrs_result_queue #(
	parameter int W = 77
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push_a,
	input  logic [W-1:0]              data_a,
	input  logic                      push_b,
	input  logic [W-1:0]              data_b,
	input  logic                      pop,
	output logic [W-1:0]              rd_data,
	output logic [lrs_pkg::QLVL_W-1:0] level
);
	import lrs_pkg::*;

	logic [W-1:0]      mem_q [QDEPTH];
	logic [QPTR_W-1:0] head_q;
	logic [QPTR_W-1:0] tail_q;
	logic [QPTR_W-1:0] tail_b;
	logic [QLVL_W-1:0] count_q;

	// The second result of an item lands behind the first when both arrive.
	assign tail_b = tail_q + QPTR_W'(push_a);

	always_ff @(posedge clk) begin
		if (push_a) begin
			mem_q[tail_q] <= data_a;
		end
		if (push_b) begin
			mem_q[tail_b] <= data_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_q + QPTR_W'(pop);
			tail_q  <= tail_q + QPTR_W'(push_a) + QPTR_W'(push_b);
			count_q <= count_q + QLVL_W'(push_a) + QLVL_W'(push_b) - QLVL_W'(pop);
		end
	end

	assign rd_data = mem_q[head_q];
	assign level   = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QLVL_W'(QDEPTH))
		else $error("result queue holds more entries than its depth");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("result queue popped while empty");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!pop && !push_a && !push_b) |=> $stable(count_q) && $stable(head_q))
		else $error("result queue moved without a push or pop");

endmodule

>>> rtl/life_rule_row_stepper.sv
// Top level of the Life row stepper: configuration registers, row history,
// two row evaluators and the result queue. Depends on lrs_pkg, lrs_row_eval,
// lrs_result_queue.
// The block computes one generation of Conway's Life (B3/S23) on a grid whose
// edges do not wrap. Rows enter on the s_ stream from the top, one row per
// item. When row r arrives, the next state of row r-1 is queued; when row r is
// the last of the frame, its own next state follows with tlast set and the
// row history clears for the next frame.
// Throughput: one input item per cycle, sustained. Each item yields at most
// one result except the last row of a frame, which yields two; the four-entry
// result queue absorbs that extra result, so a stream of frames runs at one
// row per cycle with m_tready held high.
// With nothing older queued, a result is on m_ the cycle after its row is
// accepted, and the second result of a last row follows it out of the queue. Both evaluators,
// 2 x MAX_WIDTH neighbor-counting lanes, work in the accept cycle.
// When the receiver stalls, s_tready drops once fewer than two queue entries
// are free, so nothing is lost. At reset the queue empties, the row history
// and row counter clear, grid_width returns to 64 and grid_height to 1.
// Registers are written through cfg_we/cfg_addr/cfg_wdata; index 0 is
// grid_width, index 1 is grid_height, other indexes are ignored.
module life_rule_row_stepper #(
	parameter int MAX_WIDTH = lrs_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lrs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [lrs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata fields from bit 0: row_cells, then zero fill to whole bytes.
	input  logic [((MAX_WIDTH+7)/8)*8-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata fields from bit 0: row_next, row_index, then zero fill.
	output logic [((MAX_WIDTH+lrs_pkg::INDEX_W+7)/8)*8-1:0] m_tdata,
	output logic                            m_tlast
);
	import lrs_pkg::*;

	localparam int OUT_W   = ((MAX_WIDTH + INDEX_W + 7) / 8) * 8;
	localparam int ENTRY_W = MAX_WIDTH + INDEX_W + 1;

	logic [GWIDTH_W-1:0]  grid_width_q;
	logic [HEIGHT_W-1:0]  grid_height_q;
	logic [MAX_WIDTH-1:0] upper_q;
	logic [MAX_WIDTH-1:0] middle_q;
	logic [INDEX_W-1:0]   rows_seen_q;

	logic [GWIDTH_W-1:0]  eff_width;
	logic [HEIGHT_W-1:0]  eff_height;
	logic [MAX_WIDTH-1:0] mask;
	logic [MAX_WIDTH-1:0] cur;
	logic [MAX_WIDTH-1:0] above_b;
	logic [MAX_WIDTH-1:0] next_a;
	logic [MAX_WIDTH-1:0] next_b;
	logic                 in_acc;
	logic                 has_prev;
	logic                 last_row;
	logic                 push_a;
	logic                 push_b;
	logic [ENTRY_W-1:0]   data_a;
	logic [ENTRY_W-1:0]   data_b;
	logic [ENTRY_W-1:0]   head;
	logic [QLVL_W-1:0]    level;
	logic                 pop;

	// Registers take effect at once; out-of-range values are clamped below.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_WIDTH_RST;
			grid_height_q <= GRID_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata[GWIDTH_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// A width of zero acts as one cell; anything past the lane count saturates.
	always_comb begin
		if (grid_width_q == '0) begin
			eff_width = GWIDTH_W'(1);
		end else if (grid_width_q > GWIDTH_W'(MAX_WIDTH)) begin
			eff_width = GWIDTH_W'(MAX_WIDTH);
		end else begin
			eff_width = grid_width_q;
		end
		for (int i = 0; i < MAX_WIDTH; i++) begin
			mask[i] = GWIDTH_W'(i) < eff_width;
		end
	end

	always_comb begin
		if (grid_height_q == '0) begin
			eff_height = HEIGHT_W'(1);
		end else if (grid_height_q > HEIGHT_W'(MAX_HEIGHT)) begin
			eff_height = HEIGHT_W'(MAX_HEIGHT);
		end else begin
			eff_height = grid_height_q;
		end
	end

	assign in_acc   = s_tvalid && s_tready;
	assign cur      = s_tdata[MAX_WIDTH-1:0] & mask;
	assign has_prev = rows_seen_q != '0;
	// Also true when the height was lowered below the rows already seen.
	assign last_row = ({1'b0, rows_seen_q} + HEIGHT_W'(1)) >= eff_height;

	// Evaluator A finishes the row above the arriving one; evaluator B
	// finishes the arriving row itself when it closes the frame.
	lrs_row_eval #(.MW(MAX_WIDTH)) u_eval_a (
		.above (upper_q),
		.here  (middle_q),
		.below (cur),
		.mask  (mask),
		.next  (next_a)
	);

	assign above_b = has_prev ? middle_q : '0;

	lrs_row_eval #(.MW(MAX_WIDTH)) u_eval_b (
		.above (above_b),
		.here  (cur),
		.below ('0),
		.mask  (mask),
		.next  (next_b)
	);

	assign push_a = in_acc && has_prev;
	assign push_b = in_acc && last_row;
	assign data_a = {1'b0, rows_seen_q - INDEX_W'(1), next_a};
	assign data_b = {1'b1, rows_seen_q, next_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q     <= '0;
			middle_q    <= '0;
			rows_seen_q <= '0;
		end else if (in_acc) begin
			if (last_row) begin
				upper_q     <= '0;
				middle_q    <= '0;
				rows_seen_q <= '0;
			end else begin
				upper_q     <= middle_q;
				middle_q    <= cur;
				rows_seen_q <= rows_seen_q + INDEX_W'(1);
			end
		end
	end

	lrs_result_queue #(.W(ENTRY_W)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_a  (push_a),
		.data_a  (data_a),
		.push_b  (push_b),
		.data_b  (data_b),
		.pop     (pop),
		.rd_data (head),
		.level   (level)
	);

	// Room for two results is kept free so any item can be taken.
	assign s_tready = level <= QLVL_W'(QDEPTH - 2);
	assign m_tvalid = level != '0;
	assign pop      = m_tvalid && m_tready;
	assign m_tdata  = OUT_W'(head[MAX_WIDTH+INDEX_W-1:0]);
	assign m_tlast  = head[ENTRY_W-1];

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last_row) |=> (rows_seen_q == '0) && (middle_q == '0))
		else $error("row history not cleared after the last row of a frame");

	a_row_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !last_row) |=> rows_seen_q == $past(rows_seen_q) + INDEX_W'(1))
		else $error("row counter did not advance on an inner row");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result item changed while waiting for the receiver");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for life_rule_row_stepper: directed rows and random Life frames,
// checked against an in-bench model of the row update. Depends on lrs_pkg and the
// life_rule_row_stepper RTL.
`timescale 1ns / 1ps

module testbench;
	import lrs_pkg::*;

	localparam int ROW_W    = MAX_WIDTH_DEF;
	localparam int S_DATA_W = ((ROW_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((ROW_W + INDEX_W + 7) / 8) * 8;

	// Register indexes that the block decodes to nothing.
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;

	localparam int RANDOM_ROWS  = 1435;  // random items after the directed table
	localparam int TAIL_ROWS    = 150;   // final stretch that runs without idling
	localparam int HOLD_PHASE   = 4;     // random phase in which the sink holds off
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE_WAIT  = 4;     // quiet cycles before a register write
	localparam int END_SLACK    = 20;
	localparam int STALL_LIMIT  = 3000;  // cycles with no transfer of any kind
	localparam int PRINT_CAP    = 40;

	typedef logic [ROW_W-1:0] row_t;

	// One expected result: the next state of a row, its index and the last-row mark.
	typedef struct packed {
		row_t               cells;
		logic [INDEX_W-1:0] index;
		logic               last;
	} row_result_t;

	typedef enum logic [0:0] {STEP_ROW, STEP_CFG} step_kind_t;

	// One line of the directed table. A register write uses addr and the low bits of
	// value; a row uses value as its cells, and carries a typed-in result when typed is set.
	typedef struct packed {
		step_kind_t            kind;
		logic [CFG_ADDR_W-1:0] addr;
		row_t                  value;
		logic                  typed;
		row_result_t           want;
	} step_t;

	localparam row_t ALL_ALIVE = '1;
	localparam row_t EDGES_DIE = 64'h7FFF_FFFF_FFFF_FFFE;

	localparam int PLAN_LEN = 25;
	// The block comes out of reset with width 64 and height 1, so each row of the
	// first lines is a frame of its own and its result can be read off directly.
	localparam step_t DIRECTED_PLAN [0:PLAN_LEN-1] = '{
		// An empty grid stays empty.
		'{STEP_ROW, '0, '0, 1'b1, '{'0, 12'd0, 1'b1}},
		// A full row alone: interior cells have two neighbors and survive, the two
		// end cells have one and die.
		'{STEP_ROW, '0, ALL_ALIVE, 1'b1, '{EDGES_DIE, 12'd0, 1'b1}},
		// Three in a line with dead rows above and below: only the middle survives.
		'{STEP_ROW, '0, 64'h7, 1'b1, '{64'h2, 12'd0, 1'b1}},
		// Width zero acts as one cell, which dies alone.
		'{STEP_CFG, REG_GRID_WIDTH, 64'h0, 1'b0, '0},
		'{STEP_ROW, '0, ALL_ALIVE, 1'b1, '{'0, 12'd0, 1'b1}},
		// Writes to undecoded indexes change nothing.
		'{STEP_CFG, REG_SPARE_2, 64'h1FFF, 1'b0, '0},
		'{STEP_CFG, REG_SPARE_3, 64'h1FFF, 1'b0, '0},
		'{STEP_ROW, '0, 64'h1, 1'b1, '{'0, 12'd0, 1'b1}},
		// Width above the maximum saturates to the full row.
		'{STEP_CFG, REG_GRID_WIDTH, 64'h1FFF, 1'b0, '0},
		'{STEP_ROW, '0, 64'h8000_0000_0000_0000, 1'b1, '{'0, 12'd0, 1'b1}},
		'{STEP_ROW, '0, ALL_ALIVE, 1'b1, '{EDGES_DIE, 12'd0, 1'b1}},
		// Height zero acts as a one-row frame.
		'{STEP_CFG, REG_GRID_HEIGHT, 64'h0, 1'b0, '0},
		'{STEP_ROW, '0, 64'h5555_5555_5555_5555, 1'b0, '0},
		// Narrow grid with a vertical blinker; the first row also carries cells
		// above the width that must be ignored.
		'{STEP_CFG, REG_GRID_WIDTH, 64'd5, 1'b0, '0},
		'{STEP_CFG, REG_GRID_HEIGHT, 64'd3, 1'b0, '0},
		'{STEP_ROW, '0, 64'hFFFF_FFFF_FFFF_FFE4, 1'b0, '0},
		'{STEP_ROW, '0, 64'h4, 1'b0, '0},
		'{STEP_ROW, '0, 64'h4, 1'b0, '0},
		// Height above the maximum saturates; three rows go in, then the height is
		// lowered below the rows already seen, so the next row ends the frame.
		'{STEP_CFG, REG_GRID_HEIGHT, 64'h1FFF, 1'b0, '0},
		'{STEP_CFG, REG_GRID_WIDTH, 64'd64, 1'b0, '0},
		'{STEP_ROW, '0, 64'hA5A5_5A5A_0FF0_F00F, 1'b0, '0},
		'{STEP_ROW, '0, 64'h3C3C_C3C3_1818_8181, 1'b0, '0},
		'{STEP_ROW, '0, 64'h0000_FFFF_0000_FFFF, 1'b0, '0},
		'{STEP_CFG, REG_GRID_HEIGHT, 64'd2, 1'b0, '0},
		'{STEP_ROW, '0, 64'h0F0F_0F0F_F0F0_F0F0, 1'b0, '0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  m_tlast;

	// In-bench copy of the block's registers and row history.
	logic [GWIDTH_W-1:0]   life_width   = GRID_WIDTH_RST;
	logic [HEIGHT_W-1:0]   life_height  = GRID_HEIGHT_RST;
	row_t                  row_above    = '0;
	row_t                  row_held     = '0;
	logic [INDEX_W-1:0]    rows_in_frame = '0;

	row_result_t           pending_rows [$];  // results still owed by the block
	row_result_t           step_results [$];  // results of the latest row only
	int unsigned           mismatches = 0;

	// Set by the row driver for the item it is offering; the monitor uses the typed-in
	// result in place of the computed one when this is set.
	bit                    row_is_typed = 1'b0;
	row_result_t           row_typed_res = '0;

	bit                    quiet_tail = 1'b0;
	bit                    hold_request = 1'b0;

	life_rule_row_stepper u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mask of the cells in use. A width of zero behaves as one cell and anything past
	// the row size as the whole row.
	function automatic row_t used_cells(input logic [GWIDTH_W-1:0] width);
		int unsigned w;
		w = width;
		if (w < 1) w = 1;
		if (w > ROW_W) w = ROW_W;
		if (w == ROW_W) return '1;
		return (row_t'(1) << w) - row_t'(1);
	endfunction

	// Rows per frame, clamped the same way.
	function automatic int unsigned frame_rows(input logic [HEIGHT_W-1:0] height);
		int unsigned h;
		h = height;
		if (h < 1) h = 1;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;
		return h;
	endfunction

	// B3/S23 update of one row from its two vertical neighbors. Cells past either
	// end of the row are dead.
	function automatic row_t life_next(input row_t above, input row_t here, input row_t below,
			input row_t mask);
		row_t nxt;
		logic [NBR_CNT_W-1:0] count;
		nxt = '0;
		for (int i = 0; i < ROW_W; i++) begin
			count = '0;
			for (int j = i - 1; j <= i + 1; j++) begin
				if (j >= 0 && j < ROW_W) begin
					count = count + NBR_CNT_W'(above[j]) + NBR_CNT_W'(below[j]);
					if (j != i) count = count + NBR_CNT_W'(here[j]);
				end
			end
			if (count == BIRTH_COUNT || (here[i] && count == SURVIVE_COUNT)) nxt[i] = 1'b1;
		end
		return nxt & mask;
	endfunction

	// Takes one accepted row through the frame logic. The row above it gets its next
	// state now that its lower neighbor is known; on the final row of the frame that
	// row's own next state follows, with a dead row below, and the history clears.
	task automatic step_life_rows(input row_t cells);
		row_t mask;
		row_t cur;
		int unsigned height;
		bit ends_frame;
		step_results.delete();
		mask = used_cells(life_width);
		cur = cells & mask;
		height = frame_rows(life_height);
		ends_frame = (int'(rows_in_frame) + 1 >= height);
		if (rows_in_frame != 0)
			step_results.push_back('{life_next(row_above, row_held, cur, mask),
				rows_in_frame - INDEX_W'(1), 1'b0});
		if (ends_frame) begin
			step_results.push_back('{life_next((rows_in_frame != 0) ? row_held : '0, cur, '0, mask),
				rows_in_frame, 1'b1});
			row_above = '0;
			row_held = '0;
			rows_in_frame = '0;
		end else begin
			row_above = row_held;
			row_held = cur;
			rows_in_frame = rows_in_frame + INDEX_W'(1);
		end
	endtask

	task automatic check_result();
		row_result_t want;
		if (pending_rows.size() == 0) begin
			mismatches++;
			if (mismatches <= PRINT_CAP)
				$display("%0t ns: unexpected result, expected none, got row_next %h row_index %0d last %b",
					$time, m_tdata[ROW_W-1:0], m_tdata[ROW_W +: INDEX_W], m_tlast);
		end else begin
			want = pending_rows.pop_front();
			if (m_tdata[ROW_W-1:0] !== want.cells) begin
				mismatches++;
				if (mismatches <= PRINT_CAP)
					$display("%0t ns: row_next mismatch, expected %h, got %h",
						$time, want.cells, m_tdata[ROW_W-1:0]);
			end
			if (m_tdata[ROW_W +: INDEX_W] !== want.index) begin
				mismatches++;
				if (mismatches <= PRINT_CAP)
					$display("%0t ns: row_index mismatch, expected %0d, got %0d",
						$time, want.index, m_tdata[ROW_W +: INDEX_W]);
			end
			if (m_tlast !== want.last) begin
				mismatches++;
				if (mismatches <= PRINT_CAP)
					$display("%0t ns: frame_last mismatch, expected %b, got %b",
						$time, want.last, m_tlast);
			end
		end
	endtask

	// Everything is sampled at the rising edge. A row accepted at this edge still sees
	// the old registers; a register write lands after it, as in the block.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				step_life_rows(s_tdata[ROW_W-1:0]);
				if (row_is_typed) pending_rows.push_back(row_typed_res);
				else foreach (step_results[k]) pending_rows.push_back(step_results[k]);
			end
			if (m_tvalid && m_tready) check_result();
			if (cfg_we) begin
				case (cfg_addr)
				REG_GRID_WIDTH: life_width = cfg_wdata[GWIDTH_W-1:0];
				REG_GRID_HEIGHT: life_height = cfg_wdata[HEIGHT_W-1:0];
				default: ;
				endcase
			end
		end
	end

	// Ends the run when nothing moves for too long: no item on either side and no
	// register write.
	initial begin : watchdog
		int unsigned stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("status: fail");
		$finish;
	end

	// Result side. m_tready changes only at falling edges, once per decision. Random
	// stalls mix with ready runs; on request it holds off for a long stretch so the
	// result queue fills and the block stops taking rows.
	initial begin : result_sink
		int unsigned span;
		m_tready = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				span = $urandom_range(1, 19);
				repeat (span) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
				span = quiet_tail ? 1 : $urandom_range(1, 24);
				repeat (span) @(negedge clk);
			end
		end
	end

	// Offers one row from a falling edge and returns at the falling edge after it is
	// taken, with s_tvalid still high so that back-to-back rows leave no gap.
	task automatic offer_row(input row_t cells, input bit typed, input row_result_t typed_res);
		row_is_typed = typed;
		row_typed_res = typed_res;
		s_tdata <= cells;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic sender_gap(input int unsigned cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Stops offering and waits until every owed result has come out. A first row of a
	// frame owes nothing, so a few more cycles pass before the block counts as idle.
	task automatic drain_block();
		s_tvalid <= 1'b0;
		while (pending_rows.size() != 0) @(negedge clk);
		repeat (SETTLE_WAIT) @(negedge clk);
	endtask

	// One register write, held for a single rising edge.
	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_addr <= addr;
		cfg_wdata <= data;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random row contents: mostly plain random, with sparse, dense, empty and full
	// rows mixed in so that births, survivals and deaths all occur often.
	function automatic row_t random_row();
		row_t a;
		row_t b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(0, 9))
		0: return '0;
		1: return '1;
		2, 3: return a & b;
		4: return a | b;
		5: return a & b & row_t'({$urandom, $urandom});
		default: return a;
		endcase
	endfunction

	initial begin : stimulus
		int unsigned rows_offered;
		int unsigned phase;
		int unsigned n_frames;
		int unsigned height;
		int unsigned rows;
		logic [GWIDTH_W-1:0] new_width;
		logic [HEIGHT_W-1:0] new_height;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table. Register writes wait until the block has gone quiet.
		foreach (DIRECTED_PLAN[i]) begin
			if (DIRECTED_PLAN[i].kind == STEP_CFG) begin
				drain_block();
				write_reg(DIRECTED_PLAN[i].addr, DIRECTED_PLAN[i].value[CFG_DATA_W-1:0]);
			end else begin
				offer_row(DIRECTED_PLAN[i].value, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
			end
		end

		// Random phases. Each one drains the block, picks a new width and height and
		// sends whole frames of random rows; now and then it stops part way through a
		// frame, so that the next phase may lower the height mid-frame.
		rows_offered = 0;
		phase = 0;
		while (rows_offered < RANDOM_ROWS) begin
			phase++;
			quiet_tail = (rows_offered + TAIL_ROWS >= RANDOM_ROWS);
			drain_block();

			case ($urandom_range(0, 9))
			0: new_width = 7'd0;
			1: new_width = 7'd127;
			2: new_width = 7'd64;
			3: new_width = 7'($urandom_range(65, 127));
			default: new_width = 7'($urandom_range(1, 64));
			endcase
			case ($urandom_range(0, 15))
			0: new_height = 13'd0;
			1: new_height = 13'd1;
			2: new_height = 13'($urandom_range(4097, 8191));
			3, 4: new_height = 13'($urandom_range(13, 48));
			default: new_height = 13'($urandom_range(2, 12));
			endcase
			n_frames = $urandom_range(1, 4);
			if (phase == HOLD_PHASE) begin
				new_height = 13'd20;
				n_frames = 3;
				hold_request = 1'b1;
			end

			// The bits above the width field are don't-care to the block; vary them.
			write_reg(REG_GRID_WIDTH, {6'($urandom_range(0, 63)), new_width});
			write_reg(REG_GRID_HEIGHT, new_height);
			if ($urandom_range(0, 7) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
					CFG_DATA_W'($urandom));

			height = frame_rows(new_height);
			if (height > 48) begin
				// Saturated height: only part of a frame, cut short by a later phase.
				rows = $urandom_range(5, 30);
			end else begin
				rows = n_frames * height;
				if (phase != HOLD_PHASE && height > 1 && $urandom_range(0, 3) == 0)
					rows += $urandom_range(1, height - 1);
			end
			// The last phase stops at the planned number of items.
			if (rows > RANDOM_ROWS - rows_offered)
				rows = RANDOM_ROWS - rows_offered;

			for (int k = 0; k < rows; k++) begin
				if (!quiet_tail && phase != HOLD_PHASE && $urandom_range(0, 9) == 0)
					sender_gap($urandom_range(1, 19));
				offer_row(random_row(), 1'b0, '0);
				rows_offered++;
			end
		end

		drain_block();
		repeat (END_SLACK) @(negedge clk);
		if (mismatches == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule
